[hdl/ctfc_pkg.sv]
`default_nettype none
package ctfc_pkg;

    // Default number of color table entries.
    localparam int TABLE_DEPTH_DEF = 256;

    // Configuration register indexes.
    localparam logic [1:0] REG_FADE_RED   = 2'd0;
    localparam logic [1:0] REG_FADE_GREEN = 2'd1;
    localparam logic [1:0] REG_FADE_BLUE  = 2'd2;
    localparam logic [1:0] REG_FADE_STEP  = 2'd3;

    localparam logic [5:0] FADE_STEP_RST = 6'd63;
    localparam int         FADE_SHIFT    = 6;

    // Luma weights; the divide by 100 is a multiply by 5243 / 2^19, exact for sums
    // up to 30*255 + 59*255 + 11*255.
    localparam int GRAY_R_WT   = 30;
    localparam int GRAY_G_WT   = 59;
    localparam int GRAY_B_WT   = 11;
    localparam int GRAY_RECIP  = 5243;
    localparam int GRAY_SHIFT  = 19;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_ROTATE = 2'd1,
        OP_GRAY   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_ROT,
        S_ROT_END,
        S_ROT_FIN,
        S_GRAY,
        S_GRAY_DRAIN,
        S_FADE,
        S_FADE_PIPE
    } t_state;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] step;
    } t_fade_cfg;

endpackage
`default_nettype wire

[hdl/ctfc_mem.sv]
`default_nettype none
module ctfc_mem #(
    parameter int DEPTH = ctfc_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire ctfc_pkg::t_rgb i_wr_data,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output ctfc_pkg::t_rgb      o_rd_data
);
    import ctfc_pkg::*;

    t_rgb r_mem [DEPTH];
    t_rgb r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hdl/ctfc_gray.sv]
`default_nettype none
module ctfc_gray #(
    parameter int AW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [AW-1:0]  i_addr,
    input  wire ctfc_pkg::t_rgb i_color,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output ctfc_pkg::t_rgb      o_wr_data,
    output logic                o_busy
);
    import ctfc_pkg::*;

    // stage 1: weighted sum, stage 2: reciprocal multiply
    logic          r_s1_vld;
    logic [AW-1:0] r_s1_addr;
    logic [14:0]   r_s1_sum;
    logic [14:0]   n_s1_sum;
    logic          r_s2_vld;
    logic [AW-1:0] r_s2_addr;
    logic [26:0]   r_s2_prod;
    logic [26:0]   n_s2_prod;
    logic [7:0]    luma;

    always_comb begin
        n_s1_sum = 15'(GRAY_R_WT) * 15'(i_color.r)
                 + 15'(GRAY_G_WT) * 15'(i_color.g)
                 + 15'(GRAY_B_WT) * 15'(i_color.b);
        n_s2_prod = 27'(r_s1_sum) * 27'(GRAY_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_s1_sum  <= n_s1_sum;
        r_s2_addr <= r_s1_addr;
        r_s2_prod <= n_s2_prod;
    end

    assign luma      = r_s2_prod[GRAY_SHIFT +: 8];
    assign o_wr_en   = r_s2_vld;
    assign o_wr_addr = r_s2_addr;
    assign o_wr_data = '{r: luma, g: luma, b: luma};
    assign o_busy    = r_s1_vld | r_s2_vld;

endmodule
`default_nettype wire

[hdl/ctfc_fade.sv]
`default_nettype none
module ctfc_fade (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire ctfc_pkg::t_fade_cfg i_cfg,
    input  wire ctfc_pkg::t_rgb      i_entry,
    output logic                     o_valid,
    output ctfc_pkg::t_rgb           o_color
);
    import ctfc_pkg::*;

    // (entry - target) * step, signed
    function automatic logic signed [15:0] fade_prod(
        input logic [7:0] target,
        input logic [7:0] entry,
        input logic [5:0] step
    );
        logic signed [8:0] diff;
        logic signed [6:0] stp;
        diff = $signed({1'b0, entry}) - $signed({1'b0, target});
        stp  = $signed({1'b0, step});
        return diff * stp;
    endfunction

    // target + floor(prod / 64), modulo 256
    function automatic logic [7:0] fade_sum(
        input logic [7:0]        target,
        input logic signed [15:0] prod
    );
        logic signed [15:0] q;
        q = prod >>> FADE_SHIFT;
        return target + q[7:0];
    endfunction

    logic               r_p_vld;
    logic signed [15:0] r_p_r;
    logic signed [15:0] r_p_g;
    logic signed [15:0] r_p_b;
    logic               r_o_vld;
    t_rgb               r_o_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_p_vld <= i_valid;
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_r <= fade_prod(i_cfg.red,   i_entry.r, i_cfg.step);
        r_p_g <= fade_prod(i_cfg.green, i_entry.g, i_cfg.step);
        r_p_b <= fade_prod(i_cfg.blue,  i_entry.b, i_cfg.step);
        r_o_color.r <= fade_sum(i_cfg.red,   r_p_r);
        r_o_color.g <= fade_sum(i_cfg.green, r_p_g);
        r_o_color.b <= fade_sum(i_cfg.blue,  r_p_b);
    end

    assign o_valid = r_o_vld;
    assign o_color = r_o_color;

endmodule
`default_nettype wire

[hdl/color_table_fade_cycle_gray.sv]
`default_nettype none
// Color table engine: TABLE_DEPTH entries of 24-bit RGB in one synchronous
// memory (one write port, one registered read port).
// Requests: a request is taken at a rising edge with start high and busy low.
//   write  : stores red/green/blue_in at first_index.
//   rotate : shifts first..last by one place (color cycling); one memory read
//            per entry, the previous entry's data written back in the same
//            cycle.
//   gray   : replaces each entry of first..last by (30R+59G+11B)/100 through
//            a two-stage luma pipe; one entry per cycle.
//   read   : one result, o_valid high for exactly one cycle, faded from
//            the fade color toward the entry.
// Throughput is set by the single memory read port: one entry per cycle.
// Indexes are reduced modulo TABLE_DEPTH. Reading an entry never written
// returns undefined data.
// Configuration: APB, fade_red/green/blue/step at byte addresses 0/4/8/12,
// written only while busy is low (the user's rule). pready is always high.
// Reset (synchronous, active low) returns to idle, fade color 0, step 63;
// the table contents are left as they are.
// The receiver cannot stall: each result is shown for one cycle only.
module color_table_fade_cycle_gray #(
    parameter int TABLE_DEPTH = ctfc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_first_index,
    input  wire logic [7:0]  i_last_index,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    // result channel
    output logic             o_valid,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ctfc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    // index mod depth: at most eight conditional subtracts of depth << k
    function automatic logic [AW-1:0] mod_depth(input logic [7:0] v);
        logic [20:0] t;
        t = {13'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (t >= (21'(TABLE_DEPTH) << k)) begin
                t = t - (21'(TABLE_DEPTH) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    t_fade_cfg r_cfg;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{red: 8'd0, green: 8'd0, blue: 8'd0, step: FADE_STEP_RST};
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FADE_RED:   r_cfg.red   <= pwdata[7:0];
                REG_FADE_GREEN: r_cfg.green <= pwdata[7:0];
                REG_FADE_BLUE:  r_cfg.blue  <= pwdata[7:0];
                REG_FADE_STEP:  r_cfg.step  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FADE_RED:   prdata = {24'd0, r_cfg.red};
            REG_FADE_GREEN: prdata = {24'd0, r_cfg.green};
            REG_FADE_BLUE:  prdata = {24'd0, r_cfg.blue};
            REG_FADE_STEP:  prdata = {26'd0, r_cfg.step};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_first;
    logic [AW-1:0] n_first;
    logic [AW-1:0] r_last;
    logic [AW-1:0] n_last;
    logic [AW-1:0] r_addr;     // read pointer
    logic [AW-1:0] n_addr;
    logic [AW-1:0] r_prev;     // address read in the previous issue cycle
    logic [AW-1:0] n_prev;
    logic [AW-1:0] r_rd_dst;   // where the in-flight read data goes
    logic [AW-1:0] n_rd_dst;
    logic          r_rd_vld;   // memory read data valid this cycle
    logic          n_rd_vld;
    logic          r_rd_head;  // in-flight read is the rotate's saved entry
    logic          n_rd_head;
    t_rgb          r_wcolor;
    t_rgb          n_wcolor;
    t_rgb          r_tmp;
    t_rgb          n_tmp;

    logic          accept;
    logic [AW-1:0] first_mod;
    logic [AW-1:0] last_mod;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    t_rgb          mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    t_rgb          mem_rd_data;

    logic          gray_vld;
    logic          gray_wr_en;
    logic [AW-1:0] gray_wr_addr;
    t_rgb          gray_wr_data;
    logic          gray_busy;

    logic          fade_vld;
    logic          fade_out_vld;
    t_rgb          fade_color;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start & ~busy;
    assign first_mod = mod_depth(i_first_index);
    assign last_mod  = mod_depth(i_last_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first   <= n_first;
        r_last    <= n_last;
        r_addr    <= n_addr;
        r_prev    <= n_prev;
        r_rd_dst  <= n_rd_dst;
        r_rd_head <= n_rd_head;
        r_wcolor  <= n_wcolor;
        r_tmp     <= n_tmp;
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_last      = r_last;
        n_addr      = r_addr;
        n_prev      = r_prev;
        n_rd_dst    = r_rd_dst;
        n_rd_vld    = 1'b0;
        n_rd_head   = r_rd_head;
        n_wcolor    = r_wcolor;
        n_tmp       = r_tmp;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_rd_dst;
        mem_wr_data = mem_rd_data;
        gray_vld    = 1'b0;
        fade_vld    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_first  = first_mod;
                    n_last   = last_mod;
                    n_wcolor = '{r: i_red_in, g: i_green_in, b: i_blue_in};
                    case (t_op'(i_op))
                        OP_WRITE: n_state = S_WRITE;
                        OP_ROTATE: begin
                            // rotate walks from last toward first
                            n_addr = last_mod;
                            if (first_mod != last_mod) begin
                                n_state = S_ROT;
                            end
                        end
                        OP_GRAY: begin
                            n_addr = first_mod;
                            if (first_mod <= last_mod) begin
                                n_state = S_GRAY;
                            end
                        end
                        OP_READ: n_state = S_FADE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_WRITE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_first;
                mem_wr_data = r_wcolor;
                n_state     = S_IDLE;
            end

            // Rotate: reads go last, ..., first. The entry read at last is
            // saved; every later read lands on the address read just before.
            S_ROT, S_ROT_END: begin
                if (r_rd_vld) begin
                    if (r_rd_head) begin
                        n_tmp = mem_rd_data;
                    end else begin
                        mem_wr_en = 1'b1;
                    end
                end
                if (r_state == S_ROT) begin
                    mem_rd_en = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_dst  = r_prev;
                    n_rd_head = (r_addr == r_last);
                    n_prev    = r_addr;
                    if (r_addr == r_first) begin
                        n_state = S_ROT_END;
                    end else if (r_first < r_last) begin
                        n_addr = r_addr - AW'(1);
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end else begin
                    n_state = S_ROT_FIN;
                end
            end

            S_ROT_FIN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_first;
                mem_wr_data = r_tmp;
                n_state     = S_IDLE;
            end

            // Gray: one read per cycle; the luma pipe writes each result back
            S_GRAY, S_GRAY_DRAIN: begin
                gray_vld    = r_rd_vld;
                mem_wr_en   = gray_wr_en;
                mem_wr_addr = gray_wr_addr;
                mem_wr_data = gray_wr_data;
                if (r_state == S_GRAY) begin
                    mem_rd_en = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_dst  = r_addr;
                    if (r_addr == r_last) begin
                        n_state = S_GRAY_DRAIN;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end else if (!r_rd_vld && !gray_busy && !gray_wr_en) begin
                    n_state = S_IDLE;
                end
            end

            S_FADE: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_first;
                n_rd_vld    = 1'b1;
                n_state     = S_FADE_PIPE;
            end

            S_FADE_PIPE: begin
                fade_vld = r_rd_vld;
                if (fade_out_vld) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    ctfc_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    ctfc_gray #(
        .AW (AW)
    ) u_gray (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (gray_vld),
        .i_addr    (r_rd_dst),
        .i_color   (mem_rd_data),
        .o_wr_en   (gray_wr_en),
        .o_wr_addr (gray_wr_addr),
        .o_wr_data (gray_wr_data),
        .o_busy    (gray_busy)
    );

    ctfc_fade u_fade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fade_vld),
        .i_cfg   (r_cfg),
        .i_entry (mem_rd_data),
        .o_valid (fade_out_vld),
        .o_color (fade_color)
    );

    assign o_valid     = fade_out_vld;
    assign o_red_out   = fade_color.r;
    assign o_green_out = fade_color.g;
    assign o_blue_out  = fade_color.b;

    // ---------------- assertions ----------------
    a_fade_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_READ) |-> ##4 o_valid)
        else $error("read request gave no result four cycles later");

    a_result_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_FADE_PIPE))
        else $error("result strobe outside a read request");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_wr_en)
        else $error("table written while idle");

    a_gray_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRAY) |-> (r_addr >= r_first && r_addr <= r_last))
        else $error("gray read pointer left its range");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ctfc_pkg::*;

    // Slowest correct run is roughly 460 requests, each at most a whole-table walk
    // plus start gaps; the limit leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT = 600000;
    localparam int DEPTH       = 256;
    // Settling wait: longer than a read takes from acceptance to its result.
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [7:0]  i_first_index;
    logic [7:0]  i_last_index;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic        o_valid;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    color_table_fade_cycle_gray dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .o_valid       (o_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: color table contents and fade registers.
    // Table updated at each request's accepting edge, in acceptance order.
    // ------------------------------------------------------------------
    t_rgb      shadow_table [DEPTH];
    t_fade_cfg shadow_fade;
    t_rgb      expected_colors [$];   // faded colors still owed by reads

    bit  idle_on;                     // random start gaps enabled
    int  mismatch_count;
    int  cycle_count;

    // target + floor((entry - target) * step / 64); arithmetic shift floors
    function automatic logic [7:0] fade_toward(logic [7:0] target, logic [7:0] entry,
                                               logic [5:0] step);
        int prod;
        prod = (int'(entry) - int'(target)) * int'(step);
        return 8'(int'(target) + (prod >>> 6));
    endfunction

    function automatic logic [7:0] luma_of(t_rgb c);
        int sum;
        sum = 30 * int'(c.r) + 59 * int'(c.g) + 11 * int'(c.b);
        return 8'(sum / 100);
    endfunction

    // Table update / result prediction for one accepted request.
    function automatic void apply_request(t_op op, logic [7:0] first, logic [7:0] last,
                                          t_rgb color);
        int   lo;
        int   hi;
        t_rgb held;
        t_rgb faded;
        lo = int'(first);
        hi = int'(last);
        case (op)
            OP_WRITE: begin
                shadow_table[lo] = color;
            end
            OP_ROTATE: begin
                // entry at last always lands on first; the rest slide toward last
                held = shadow_table[hi];
                if (lo < hi) begin
                    for (int i = hi; i > lo; i--) shadow_table[i] = shadow_table[i - 1];
                    shadow_table[lo] = held;
                end else if (lo > hi) begin
                    for (int i = hi; i < lo; i++) shadow_table[i] = shadow_table[i + 1];
                    shadow_table[lo] = held;
                end
            end
            OP_GRAY: begin
                // reversed range is empty
                for (int i = lo; i <= hi; i++) begin
                    held.r = luma_of(shadow_table[i]);
                    held.g = held.r;
                    held.b = held.r;
                    shadow_table[i] = held;
                end
            end
            OP_READ: begin
                faded.r = fade_toward(shadow_fade.red,   shadow_table[lo].r, shadow_fade.step);
                faded.g = fade_toward(shadow_fade.green, shadow_table[lo].g, shadow_fade.step);
                faded.b = fade_toward(shadow_fade.blue,  shadow_table[lo].b, shadow_fade.step);
                expected_colors.push_back(faded);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reads outstanding",
                     $realtime, cycle_count, expected_colors.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed color.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_colors.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h %h %h",
                         $realtime, o_red_out, o_green_out, o_blue_out);
            end else begin
                want = expected_colors.pop_front();
                if (o_red_out !== want.r || o_green_out !== want.g ||
                    o_blue_out !== want.b) begin
                    mismatch_count++;
                    if (o_red_out !== want.r)
                        $display("%0t: red mismatch, expected %h, actual %h",
                                 $realtime, want.r, o_red_out);
                    if (o_green_out !== want.g)
                        $display("%0t: green mismatch, expected %h, actual %h",
                                 $realtime, want.g, o_green_out);
                    if (o_blue_out !== want.b)
                        $display("%0t: blue mismatch, expected %h, actual %h",
                                 $realtime, want.b, o_blue_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Fields carry junk while start is low; the block must ignore them.
    task automatic idle_cycle();
        @(negedge i_clk);
        start         <= 1'b0;
        i_op          <= 2'($urandom);
        i_first_index <= 8'($urandom);
        i_last_index  <= 8'($urandom);
        i_red_in      <= 8'($urandom);
        i_green_in    <= 8'($urandom);
        i_blue_in     <= 8'($urandom);
    endtask

    // Returns at the accepting edge with start still high; the next call (or
    // drain_block) changes it at the following falling edge.
    task automatic send_request(t_op op, logic [7:0] first, logic [7:0] last,
                                t_rgb color);
        while (idle_on && $urandom_range(99) < 36) idle_cycle();
        @(negedge i_clk);
        start         <= 1'b1;
        i_op          <= op;
        i_first_index <= first;
        i_last_index  <= last;
        i_red_in      <= color.r;
        i_green_in    <= color.g;
        i_blue_in     <= color.b;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_request(op, first, last, color);
    endtask

    // Idle, every read answered, pipeline flushed.
    task automatic drain_block();
        idle_cycle();
        do @(posedge i_clk); while (busy !== 1'b0 || expected_colors.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [1:0] reg_idx, logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want) begin
            mismatch_count++;
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $realtime, reg_idx, want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only while idle: drains first, then writes all four and reads them back.
    task automatic set_fade(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [5:0] step);
        drain_block();
        apb_write(REG_FADE_RED,   32'(r));
        apb_write(REG_FADE_GREEN, 32'(g));
        apb_write(REG_FADE_BLUE,  32'(b));
        apb_write(REG_FADE_STEP,  32'(step));
        shadow_fade.red   = r;
        shadow_fade.green = g;
        shadow_fade.blue  = b;
        shadow_fade.step  = step;
        apb_check(REG_FADE_RED,   32'(r));
        apb_check(REG_FADE_GREEN, 32'(g));
        apb_check(REG_FADE_BLUE,  32'(b));
        apb_check(REG_FADE_STEP,  32'(step));
    endtask

    function automatic t_rgb rand_color();
        t_rgb c;
        c = 24'($urandom);
        // push channels to the rails now and then
        if ($urandom_range(7) == 0) c.r = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(7) == 0) c.g = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(7) == 0) c.b = $urandom_range(1) ? 8'hff : 8'h00;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before the table is filled: only entries 0..3, 254 and 255 are touched,
    // each written before it is read, rotated or grayed.
    // Fade registers are at reset (black, step 63); red and step checked first.
    task automatic test_directed_ops();
        apb_check(REG_FADE_RED,   32'd0);
        apb_check(REG_FADE_STEP,  32'(FADE_STEP_RST));
        send_request(OP_WRITE,  8'd0,   8'd0,   24'h000000);
        send_request(OP_WRITE,  8'd255, 8'd0,   24'hffffff);
        send_request(OP_WRITE,  8'd1,   8'd200, 24'hff0080);
        send_request(OP_WRITE,  8'd2,   8'd17,  24'h00ff01);
        send_request(OP_WRITE,  8'd3,   8'd255, 24'h123456);
        send_request(OP_READ,   8'd0,   8'd99,  24'hffffff);
        send_request(OP_READ,   8'd255, 8'd0,   24'h000000);
        send_request(OP_READ,   8'd1,   8'd0,   24'h000000);
        // rotate up: 3 wraps to 0
        send_request(OP_ROTATE, 8'd0,   8'd3,   24'h000000);
        send_request(OP_READ,   8'd0,   8'd0,   24'h000000);
        // rotate down: 0 goes to 3, the rest slide down
        send_request(OP_ROTATE, 8'd3,   8'd0,   24'h000000);
        send_request(OP_READ,   8'd3,   8'd0,   24'h000000);
        // equal indices: no change
        send_request(OP_ROTATE, 8'd2,   8'd2,   24'h000000);
        send_request(OP_READ,   8'd2,   8'd0,   24'h000000);
        send_request(OP_GRAY,   8'd1,   8'd3,   24'h000000);
        send_request(OP_READ,   8'd1,   8'd0,   24'h000000);
        send_request(OP_READ,   8'd3,   8'd0,   24'h000000);
        // reversed gray range is empty
        send_request(OP_GRAY,   8'd3,   8'd1,   24'h000000);
        send_request(OP_WRITE,  8'd254, 8'd0,   24'h80ff7f);
        // rotate across the top of the table
        send_request(OP_ROTATE, 8'd254, 8'd255, 24'h000000);
        send_request(OP_READ,   8'd254, 8'd0,   24'h000000);
        send_request(OP_READ,   8'd255, 8'd0,   24'h000000);
        send_request(OP_GRAY,   8'd255, 8'd255, 24'h000000);
        send_request(OP_READ,   8'd255, 8'd0,   24'h000000);
    endtask

    // Every entry gets a color, so later ranges may go anywhere.
    task automatic test_fill_table();
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_WRITE, 8'(i), 8'($urandom), rand_color());
    endtask

    // Fade registers at their extremes, a few reads each.
    task automatic test_fade_extremes();
        logic [7:0] fr [4] = '{8'hff, 8'h00, 8'hff, 8'h00};
        logic [7:0] fg [4] = '{8'hff, 8'h00, 8'h00, 8'hff};
        logic [7:0] fb [4] = '{8'hff, 8'h00, 8'hff, 8'h00};
        logic [5:0] fs [4] = '{6'd0, 6'd63, 6'd63, 6'd1};
        for (int k = 0; k < 4; k++) begin
            set_fade(fr[k], fg[k], fb[k], fs[k]);
            send_request(OP_READ, 8'd0,   8'($urandom), rand_color());
            send_request(OP_READ, 8'd255, 8'($urandom), rand_color());
            send_request(OP_READ, 8'($urandom), 8'($urandom), rand_color());
            send_request(OP_READ, 8'($urandom), 8'($urandom), rand_color());
        end
    endtask

    // Mixed traffic in phases, each under its own fade setting. Ranges are
    // mostly short; now and then the whole table is walked.
    task automatic test_random_traffic();
        int         pick;
        int         a;
        int         b;
        logic [7:0] first;
        logic [7:0] last;
        t_op        op;
        for (int phase = 0; phase < 6; phase++) begin
            set_fade(8'($urandom), 8'($urandom), 8'($urandom),
                     (phase == 1) ? 6'd0 : (phase == 4) ? 6'd63 : 6'($urandom));
            // one phase runs back-to-back with no start gaps
            idle_on = (phase != 3);
            for (int n = 0; n < 26; n++) begin
                pick = $urandom_range(99);
                op   = (pick < 30) ? OP_WRITE : (pick < 50) ? OP_ROTATE :
                       (pick < 62) ? OP_GRAY : OP_READ;
                if ($urandom_range(99) < 4) begin
                    a = 0;
                    b = DEPTH - 1;
                end else begin
                    a = $urandom_range(DEPTH - 1);
                    b = a + $urandom_range(15);
                    if (b > DEPTH - 1) b = DEPTH - 1;
                end
                // reversed order: downward rotate, or empty gray range
                if ((op == OP_ROTATE && $urandom_range(1)) ||
                    (op == OP_GRAY && $urandom_range(9) == 0)) begin
                    first = 8'(b);
                    last  = 8'(a);
                end else begin
                    first = 8'(a);
                    last  = 8'(b);
                end
                send_request(op, first, last, rand_color());
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        shadow_fade    = '{red: 8'd0, green: 8'd0, blue: 8'd0, step: FADE_STEP_RST};
        foreach (shadow_table[i]) shadow_table[i] = '0;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = OP_WRITE;
        i_first_index = '0;
        i_last_index  = '0;
        i_red_in      = '0;
        i_green_in    = '0;
        i_blue_in     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed_ops();
        test_fill_table();
        test_fade_extremes();
        test_random_traffic();

        // all reads answered, then a quiet tail for stray strobes
        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
